// ===== design/stb_pkg.sv =====
// Shared constants for the software timer bank: bank size, field widths
// and item kind codes. No dependencies.
`timescale 1ns / 1ps

package stb_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int ADDR_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  localparam int KIND_W  = 3;
  localparam int INDEX_W = 4;
  localparam int DELAY_W = 16;
  localparam int DELTA_W = 8;
  localparam int STAMP_W = 32;
  localparam int ENTRY_W = STAMP_W + DELAY_W;

  // index widened far enough to compare against bank sizes up to 511
  localparam int IDX_EXT_W = 9;

  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESET     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOPWATCH = 3'd4;

endpackage

// ===== design/stb_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/software_timer_bank.sv =====
// Top level of the software timer bank with stopwatch.
// Depends on stb_pkg and stb_ram (start stamp and delay per timer).
`timescale 1ns / 1ps
//
// Usage:
//   Command channel: drive kind, timer_index, delay and tick_delta with start
//   high; the beat is taken at a rising edge where busy is low.
//   Result channel: done is high for exactly one cycle, registered from busy,
//   with timed_out and elapsed valid in that cycle. Every command gives one
//   result; the receiver cannot stall it.
//   A new command is not taken while busy is high; busy is high for the
//   cycle in which the stamp and delay read from the timer RAM (registered
//   read) are compared and answered.
//   Start, reset and tick take effect at the accepting edge; the expired
//   flag set by a timeout query is written on the edge that raises done.
//   Reset: rst clears the time of day, all running and expired flags, busy
//   and done. The timer RAM is not cleared; an entry is used only for a
//   running timer, which a start has written.
//   Indexes at or beyond the bank size and kinds 5 to 7 change nothing and
//   answer zero.

module software_timer_bank (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [stb_pkg::KIND_W-1:0]        kind,
  input  logic [stb_pkg::INDEX_W-1:0]       timer_index,
  input  logic [stb_pkg::DELAY_W-1:0]       delay,
  input  logic [stb_pkg::DELTA_W-1:0]       tick_delta,
  output logic                              done,
  output logic                              timed_out,
  output logic signed [stb_pkg::STAMP_W-1:0] elapsed
);

  logic [stb_pkg::STAMP_W-1:0]   now_ms;
  logic [stb_pkg::TIMER_COUNT-1:0] running;
  logic [stb_pkg::TIMER_COUNT-1:0] expired;

  logic [stb_pkg::IDX_EXT_W-1:0] idx_ext;
  logic [stb_pkg::ADDR_W-1:0]    addr;
  logic                          idx_ok;
  logic                          accept;
  logic                          arm;

  logic [stb_pkg::KIND_W-1:0]    op_kind;
  logic [stb_pkg::ADDR_W-1:0]    op_addr;
  logic                          op_ok;
  logic                          op_running;
  logic                          op_expired;

  logic [stb_pkg::ENTRY_W-1:0]   rd_entry;
  logic [stb_pkg::STAMP_W-1:0]   rd_stamp;
  logic [stb_pkg::DELAY_W-1:0]   rd_delay;
  logic [stb_pkg::STAMP_W-1:0]   span;
  logic                          reached;
  logic                          to_next;
  logic [stb_pkg::STAMP_W-1:0]   el_next;
  logic                          set_expired;

  assign idx_ext = {{(stb_pkg::IDX_EXT_W - stb_pkg::INDEX_W){1'b0}}, timer_index};
  assign addr    = idx_ext[stb_pkg::ADDR_W-1:0];
  assign idx_ok  = idx_ext < stb_pkg::IDX_EXT_W'(stb_pkg::TIMER_COUNT);
  assign accept  = start && !busy;
  assign arm     = accept && idx_ok && (kind == stb_pkg::KIND_START) && !running[addr];

  stb_ram #(
    .WIDTH(stb_pkg::ENTRY_W),
    .DEPTH(stb_pkg::TIMER_COUNT)
  ) u_entry_ram (
    .clk  (clk),
    .we   (arm),
    .waddr(addr),
    .wdata({now_ms, delay}),
    .re   (accept),
    .raddr(addr),
    .rdata(rd_entry)
  );

  assign rd_stamp = rd_entry[stb_pkg::ENTRY_W-1:stb_pkg::DELAY_W];
  assign rd_delay = rd_entry[stb_pkg::DELAY_W-1:0];
  assign span     = now_ms - rd_stamp;
  assign reached  = span >= {{(stb_pkg::STAMP_W - stb_pkg::DELAY_W){1'b0}}, rd_delay};

  always_comb begin
    to_next     = 1'b0;
    el_next     = '0;
    set_expired = 1'b0;
    if (op_ok) begin
      case (op_kind)
        stb_pkg::KIND_TIMEOUT: begin
          if (op_expired) begin
            to_next = 1'b1;
          end else if (op_running && reached) begin
            to_next     = 1'b1;
            set_expired = 1'b1;
          end
        end
        stb_pkg::KIND_STOPWATCH: begin
          if (op_running) begin
            el_next = span;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // command beat: hold item for the answer cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind    <= kind;
      op_addr    <= addr;
      op_ok      <= idx_ok;
      op_running <= running[addr];
      op_expired <= expired[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      now_ms  <= '0;
      running <= '0;
      expired <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (accept && (kind == stb_pkg::KIND_TICK)) begin
        now_ms <= now_ms + {{(stb_pkg::STAMP_W - stb_pkg::DELTA_W){1'b0}}, tick_delta};
      end
      if (arm) begin
        running[addr] <= 1'b1;
        expired[addr] <= 1'b0;
      end
      if (accept && idx_ok && (kind == stb_pkg::KIND_RESET)) begin
        running[addr] <= 1'b0;
        expired[addr] <= 1'b0;
      end
      if (busy && set_expired) begin
        expired[op_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      timed_out <= to_next;
      elapsed   <= el_next;
    end
  end

  // each accepted beat is answered by done, which is registered from busy
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result strobe missing after command beat");

  a_done_has_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without command in flight");

  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_expired_running: assert property (@(posedge clk) disable iff (rst)
    (busy && set_expired) |-> op_running)
    else $error("expired set on an idle timer");

endmodule
